// ===== src/ri2pc_pkg.sv =====
// Shared types, constants and helper functions for the range image to point cloud unit.
package ri2pc_pkg;

   localparam int PI_Q13      = 25736;
   localparam int TWO_PI_Q13  = 51472;
   localparam int HALF_PI_Q13 = 12868;

   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_GAIN  = 652032874;
   localparam int CORD_W       = 33;
   localparam int Z_W          = 20;

   localparam int NUM_W = 29;
   localparam int DEN_W = 13;

   // wrap: u = a + pi + bias, bias is a multiple of 2pi that keeps u positive
   localparam int  WRAP_BIAS  = PI_Q13 + 51472 * 20862;
   localparam int  WRAP_RECIP = 83442;

   localparam int OUT_MAX = 2097151;
   localparam int OUT_MIN = -2097152;

   localparam int ATAN_Q16 [CORDIC_STEPS] = '{
      51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   localparam logic signed [15:0] DEF_ANGLES [32] = '{
      16'sd2877, 16'sd2697, 16'sd2515, 16'sd2331, 16'sd2142, 16'sd1952, 16'sd1760,
      16'sd1564, 16'sd1373, 16'sd1177, 16'sd977, 16'sd779, 16'sd579, 16'sd376,
      16'sd176, -16'sd24, -16'sd226, -16'sd426, -16'sd626, -16'sd829, -16'sd1027,
      -16'sd1222, -16'sd1418, -16'sd1613, -16'sd1806, -16'sd1999, -16'sd2186,
      -16'sd2372, -16'sd2556, -16'sd2738, -16'sd2917, -16'sd3093
   };

   typedef enum logic [2:0] {
      CSR_COLUMNS     = 3'd0,
      CSR_ROWS        = 3'd1,
      CSR_AZ_START    = 3'd2,
      CSR_AZ_END      = 3'd3,
      CSR_EL_START    = 3'd4,
      CSR_EL_END      = 3'd5,
      CSR_RANGE_SCALE = 3'd6,
      CSR_EL_LINEAR   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [31:0]        r16;
      logic               az_neg;
      logic               el_neg;
      logic               use_q;
      logic signed [15:0] el_fix;
   } ri2pc_tag_type;

   function automatic logic signed [15:0] def_angle(input logic [6:0] row);
      if (row < 7'd32) begin
         return DEF_ANGLES[row[4:0]];
      end
      return 16'sd0;
   endfunction

   function automatic logic [21:0] sat22(input logic signed [47:0] v);
      if (v > 48'(OUT_MAX)) begin
         return 22'(OUT_MAX);
      end
      if (v < 48'(OUT_MIN)) begin
         return 22'(OUT_MIN);
      end
      return v[21:0];
   endfunction

endpackage

// ===== src/range_image_to_point_cloud_unit.sv =====
// Top level: range image pixel to Cartesian point, fully pipelined.
// Throughput: one word per cycle; depth is set by the 29-stage column and row divider
// and the 16-step CORDIC. A stalled rsp word holds the whole pipeline.
// Reset (synchronous): pipeline emptied, registers to defaults, elevation
// table back to the default angles.
module range_image_to_point_cloud_unit #(
   parameter int MAX_ROWS = 128,
   parameter int COL_BITS = 13
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // row[6:0], col[19:7], pixel_value[35:20], table_angle[51:36]
   input  logic        req_tuser,  // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // x_coord[21:0], y_coord[43:22], z_coord[65:44]
   input  logic        csr_wen,
   input  logic [2:0]  csr_addr,
   input  logic [23:0] csr_wdata
);

   localparam int AW = $clog2(MAX_ROWS);
   localparam int CB = (COL_BITS < 13) ? COL_BITS : 13;
   localparam int NW = ri2pc_pkg::NUM_W;
   localparam int DW = ri2pc_pkg::DEN_W;
   localparam int CW = ri2pc_pkg::CORD_W;
   localparam int TW = $bits(ri2pc_pkg::ri2pc_tag_type);

   // config
   logic [12:0]        columns_ff;
   logic [7:0]         rows_ff;
   logic signed [15:0] az_start_ff, az_end_ff, el_start_ff, el_end_ff;
   logic [23:0]        scale_ff;
   logic               linear_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff  <= 13'd1024;
         rows_ff     <= 8'd32;
         az_start_ff <= -16'sd25736;
         az_end_ff   <= 16'sd25736;
         el_start_ff <= 16'sd2877;
         el_end_ff   <= -16'sd3093;
         scale_ff    <= 24'd66970;
         linear_ff   <= 1'b0;
      end else if (csr_wen) begin
         unique case (ri2pc_pkg::csr_index_type'(csr_addr))
            ri2pc_pkg::CSR_COLUMNS:     columns_ff  <= csr_wdata[12:0];
            ri2pc_pkg::CSR_ROWS:        rows_ff     <= csr_wdata[7:0];
            ri2pc_pkg::CSR_AZ_START:    az_start_ff <= $signed(csr_wdata[15:0]);
            ri2pc_pkg::CSR_AZ_END:      az_end_ff   <= $signed(csr_wdata[15:0]);
            ri2pc_pkg::CSR_EL_START:    el_start_ff <= $signed(csr_wdata[15:0]);
            ri2pc_pkg::CSR_EL_END:      el_end_ff   <= $signed(csr_wdata[15:0]);
            ri2pc_pkg::CSR_RANGE_SCALE: scale_ff    <= csr_wdata;
            ri2pc_pkg::CSR_EL_LINEAR:   linear_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic        en, acc, wr, inr;
   logic [6:0]  req_row;
   logic [12:0] req_col;
   logic [15:0] req_pix;
   logic [15:0] req_angle;
   logic [AW-1:0] addr;
   logic [12:0] cols_eff, rows_den;

   assign en        = ~rsp_tvalid | rsp_tready;
   assign req_tready = en;
   assign acc       = req_tvalid & en;
   assign req_row   = req_tdata[6:0];
   assign req_col   = 13'(req_tdata[7 +: CB]);
   assign req_pix   = req_tdata[35:20];
   assign req_angle = req_tdata[51:36];
   assign addr      = AW'(req_row);
   assign inr       = (32'(req_row) < MAX_ROWS);
   assign wr        = acc & req_tuser & inr;
   assign cols_eff  = (columns_ff == 13'd0) ? 13'd1 : columns_ff;
   assign rows_den  = (rows_ff > 8'd1) ? 13'(rows_ff - 8'd1) : 13'd1;

   // elevation table
   logic [15:0]         mem_ff [MAX_ROWS];
   logic [MAX_ROWS-1:0] ent_ff;

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[addr] <= req_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= '0;
      end else if (wr) begin
         ent_ff[addr] <= 1'b1;
      end
   end

   // stage 1
   logic        s1_vld_ff, s1_vld_in;
   logic [6:0]  s1_row_ff;
   logic [12:0] s1_col_ff;
   logic [15:0] s1_pix_ff, s1_tbl_ff;
   logic        s1_inr_ff, s1_ent_ff;

   assign s1_vld_in = acc & ~req_tuser & (req_pix != 16'd0) & (scale_ff != 24'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_row_ff <= req_row;
         s1_col_ff <= req_col;
         s1_pix_ff <= req_pix;
         s1_inr_ff <= inr;
         s1_tbl_ff <= mem_ff[addr];
         s1_ent_ff <= ent_ff[addr];
      end
   end

   // stage 2
   logic               s2_vld_ff;
   logic signed [30:0] s2_azp_ff, s2_azp_in, s2_elp_ff, s2_elp_in;
   logic [39:0]        s2_rraw_ff, s2_rraw_in;
   logic signed [15:0] s2_fix_ff, s2_fix_in;
   logic signed [16:0] az_diff, el_diff;

   always_comb begin
      az_diff    = 17'(az_end_ff) - 17'(az_start_ff);
      el_diff    = 17'(el_end_ff) - 17'(el_start_ff);
      s2_azp_in  = 31'(az_diff) * 31'($signed({1'b0, s1_col_ff}));
      s2_elp_in  = 31'(el_diff) * 31'($signed({1'b0, s1_row_ff}));
      s2_rraw_in = 40'(s1_pix_ff) * 40'(scale_ff);
      if (linear_ff) begin
         s2_fix_in = el_start_ff;
      end else if (!s1_inr_ff) begin
         s2_fix_in = 16'sd0;
      end else if (s1_ent_ff) begin
         s2_fix_in = $signed(s1_tbl_ff);
      end else begin
         s2_fix_in = ri2pc_pkg::def_angle(s1_row_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_azp_ff  <= s2_azp_in;
         s2_elp_ff  <= s2_elp_in;
         s2_rraw_ff <= s2_rraw_in;
         s2_fix_ff  <= s2_fix_in;
      end
   end

   // stage 3: magnitudes plus half divisor
   logic                       s3_vld_ff;
   logic [1:0][NW-1:0]         s3_num_ff, s3_num_in;
   ri2pc_pkg::ri2pc_tag_type   s3_tag_ff, s3_tag_in;
   logic [30:0]                az_mag, el_mag;
   logic [1:0][DW-1:0]         div_den;

   always_comb begin
      az_mag = s2_azp_ff[30] ? 31'(-s2_azp_ff) : 31'(s2_azp_ff);
      el_mag = s2_elp_ff[30] ? 31'(-s2_elp_ff) : 31'(s2_elp_ff);
      s3_num_in[0]     = NW'(az_mag) + NW'(cols_eff >> 1);
      s3_num_in[1]     = NW'(el_mag) + NW'(rows_den >> 1);
      s3_tag_in.r16    = 32'((s2_rraw_ff + 40'd128) >> 8);
      s3_tag_in.az_neg = s2_azp_ff[30];
      s3_tag_in.el_neg = s2_elp_ff[30];
      s3_tag_in.use_q  = linear_ff & (rows_ff > 8'd1);
      s3_tag_in.el_fix = s2_fix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_num_ff <= s3_num_in;
         s3_tag_ff <= s3_tag_in;
      end
   end

   assign div_den[0] = cols_eff;
   assign div_den[1] = rows_den;

   logic                     dv_vld;
   logic [1:0][NW-1:0]       dv_quo;
   ri2pc_pkg::ri2pc_tag_type dv_tag;

   ri2pc_div #(
      .NW(NW), .DW(DW), .TW(TW), .LANES(2)
   ) u_div (
      .clock(clock), .reset(reset), .en(en),
      .in_vld(s3_vld_ff), .in_num(s3_num_ff), .in_den(div_den), .in_tag(s3_tag_ff),
      .out_vld(dv_vld), .out_quo(dv_quo), .out_tag(dv_tag)
   );

   // stage after divider: raw angles
   logic               e0_vld_ff;
   logic [1:0][31:0]   e0_ang_ff, e0_ang_in;
   logic [31:0]        e0_r16_ff;
   logic signed [31:0] sq_az, sq_el;

   always_comb begin
      sq_az = $signed({3'b000, dv_quo[0]});
      sq_el = $signed({3'b000, dv_quo[1]});
      if (dv_tag.az_neg) begin
         sq_az = -sq_az;
      end
      if (dv_tag.el_neg) begin
         sq_el = -sq_el;
      end
      e0_ang_in[0] = -sq_az - 32'(az_start_ff) - 32'(ri2pc_pkg::PI_Q13);
      e0_ang_in[1] = dv_tag.use_q ? (sq_el + 32'(el_start_ff)) : 32'(dv_tag.el_fix);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_vld_ff <= 1'b0;
      end else if (en) begin
         e0_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e0_ang_ff <= e0_ang_in;
         e0_r16_ff <= dv_tag.r16;
      end
   end

   logic             wp_vld;
   logic [1:0][15:0] wp_ang;
   logic [31:0]      wp_r16;

   ri2pc_wrap #(
      .TW(32), .LANES(2)
   ) u_wrap (
      .clock(clock), .reset(reset), .en(en),
      .in_vld(e0_vld_ff), .in_ang(e0_ang_ff), .in_tag(e0_r16_ff),
      .out_vld(wp_vld), .out_ang(wp_ang), .out_tag(wp_r16)
   );

   logic               cd_vld;
   logic [1:0][CW-1:0] cd_cos, cd_sin;
   logic [31:0]        cd_r16;

   ri2pc_cordic #(
      .TW(32), .LANES(2)
   ) u_cordic (
      .clock(clock), .reset(reset), .en(en),
      .in_vld(wp_vld), .in_ang(wp_ang), .in_tag(wp_r16),
      .out_vld(cd_vld), .out_cos(cd_cos), .out_sin(cd_sin), .out_tag(cd_r16)
   );

   // scaling stages, lane 0 azimuth, lane 1 elevation
   logic               g1_vld_ff, g2_vld_ff, g3_vld_ff, g4_vld_ff;
   logic signed [65:0] g1_hp_ff, g1_hp_in, g1_zp_ff, g1_zp_in;
   logic [CW-1:0]      g1_ca_ff, g1_sa_ff, g2_ca_ff, g2_sa_ff;
   logic signed [33:0] g2_h_ff, g2_h_in;
   logic [21:0]        g2_z_ff, g2_z_in, g3_z_ff, g4_z_ff;
   logic signed [66:0] g3_xp_ff, g3_xp_in, g3_yp_ff, g3_yp_in;
   logic [21:0]        g4_x_ff, g4_x_in, g4_y_ff, g4_y_in;

   always_comb begin
      g1_hp_in = 66'($signed({1'b0, cd_r16})) * 66'($signed(cd_cos[1]));
      g1_zp_in = 66'($signed({1'b0, cd_r16})) * 66'($signed(cd_sin[1]));
      g2_h_in  = 34'((g1_hp_ff + (66'sd1 <<< 29)) >>> 30);
      g2_z_in  = ri2pc_pkg::sat22(48'((g1_zp_ff + (66'sd1 <<< 35)) >>> 36));
      g3_xp_in = 67'(g2_h_ff) * 67'($signed(g2_ca_ff));
      g3_yp_in = 67'(g2_h_ff) * 67'($signed(g2_sa_ff));
      g4_x_in  = ri2pc_pkg::sat22(48'((g3_xp_ff + (67'sd1 <<< 35)) >>> 36));
      g4_y_in  = ri2pc_pkg::sat22(48'((g3_yp_ff + (67'sd1 <<< 35)) >>> 36));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g1_vld_ff <= 1'b0;
         g2_vld_ff <= 1'b0;
         g3_vld_ff <= 1'b0;
         g4_vld_ff <= 1'b0;
      end else if (en) begin
         g1_vld_ff <= cd_vld;
         g2_vld_ff <= g1_vld_ff;
         g3_vld_ff <= g2_vld_ff;
         g4_vld_ff <= g3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g1_hp_ff <= g1_hp_in;
         g1_zp_ff <= g1_zp_in;
         g1_ca_ff <= cd_cos[0];
         g1_sa_ff <= cd_sin[0];
         g2_h_ff  <= g2_h_in;
         g2_z_ff  <= g2_z_in;
         g2_ca_ff <= g1_ca_ff;
         g2_sa_ff <= g1_sa_ff;
         g3_xp_ff <= g3_xp_in;
         g3_yp_ff <= g3_yp_in;
         g3_z_ff  <= g2_z_ff;
         g4_x_ff  <= g4_x_in;
         g4_y_ff  <= g4_y_in;
         g4_z_ff  <= g3_z_ff;
      end
   end

   assign rsp_tvalid = g4_vld_ff;
   assign rsp_tdata  = {6'b000000, g4_z_ff, g4_y_ff, g4_x_ff};

endmodule

// ===== src/ri2pc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing a tag.
module ri2pc_div #(
   parameter int NW    = 29,
   parameter int DW    = 13,
   parameter int TW    = 1,
   parameter int LANES = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_vld,
   input  logic [LANES-1:0][NW-1:0]     in_num,
   input  logic [LANES-1:0][DW-1:0]     in_den,
   input  logic [TW-1:0]                in_tag,
   output logic                         out_vld,
   output logic [LANES-1:0][NW-1:0]     out_quo,
   output logic [TW-1:0]                out_tag
);

   logic [NW-1:0]                        vld_ff;
   logic [NW-1:0][TW-1:0]                tag_ff;
   logic [NW-1:0][LANES-1:0][DW-1:0]     rem_ff;
   logic [NW-1:0][LANES-1:0][NW-1:0]     nq_ff;
   logic [NW-1:0][LANES-1:0][DW-1:0]     den_ff;

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic                     vld_src;
      logic [TW-1:0]            tag_src;
      logic [LANES-1:0][DW-1:0] rem_src;
      logic [LANES-1:0][NW-1:0] nq_src;
      logic [LANES-1:0][DW-1:0] den_src;
      logic [LANES-1:0][DW-1:0] rem_in;
      logic [LANES-1:0][NW-1:0] nq_in;

      if (s == 0) begin : g_first
         assign vld_src = in_vld;
         assign tag_src = in_tag;
         assign rem_src = '0;
         assign nq_src  = in_num;
         assign den_src = in_den;
      end else begin : g_next
         assign vld_src = vld_ff[s-1];
         assign tag_src = tag_ff[s-1];
         assign rem_src = rem_ff[s-1];
         assign nq_src  = nq_ff[s-1];
         assign den_src = den_ff[s-1];
      end

      always_comb begin
         logic [DW:0] r2;
         logic        qbit;
         for (int l = 0; l < LANES; l++) begin
            r2 = {rem_src[l], nq_src[l][NW-1]};
            qbit = (r2 >= {1'b0, den_src[l]});
            if (qbit) begin
               rem_in[l] = DW'(r2 - {1'b0, den_src[l]});
            end else begin
               rem_in[l] = DW'(r2);
            end
            nq_in[l] = {nq_src[l][NW-2:0], qbit};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[s] <= tag_src;
            rem_ff[s] <= rem_in;
            nq_ff[s]  <= nq_in;
            den_ff[s] <= den_src;
         end
      end
   end

   assign out_vld = vld_ff[NW-1];
   assign out_quo = nq_ff[NW-1];
   assign out_tag = tag_ff[NW-1];

endmodule

// ===== src/ri2pc_wrap.sv =====
// Angle wrap into [-pi, pi) by constant reciprocal reduction modulo 2pi, four stages.
module ri2pc_wrap #(
   parameter int TW    = 32,
   parameter int LANES = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_vld,
   input  logic [LANES-1:0][31:0]   in_ang,
   input  logic [TW-1:0]            in_tag,
   output logic                     out_vld,
   output logic [LANES-1:0][15:0]   out_ang,
   output logic [TW-1:0]            out_tag
);

   localparam int NST = 4;

   logic [NST-1:0]           vld_ff;
   logic [NST-1:0][TW-1:0]   tag_ff;
   logic [LANES-1:0][31:0]   u1_ff, u1_in, u2_ff, u3_ff;
   logic [LANES-1:0][16:0]   k2_ff, k2_in;
   logic [LANES-1:0][31:0]   p3_ff, p3_in;
   logic [LANES-1:0][15:0]   a4_ff, a4_in;

   always_comb begin
      logic [16:0] rr;
      for (int l = 0; l < LANES; l++) begin
         u1_in[l] = 32'(33'($signed(in_ang[l])) + 33'(ri2pc_pkg::WRAP_BIAS));
         k2_in[l] = 17'((64'(u1_ff[l]) * 64'(ri2pc_pkg::WRAP_RECIP)) >> 32);
         p3_in[l] = 32'(k2_ff[l]) * 32'(ri2pc_pkg::TWO_PI_Q13);
         rr = 17'(u3_ff[l] - p3_ff[l]);
         if (rr >= 17'(ri2pc_pkg::TWO_PI_Q13)) begin
            rr = rr - 17'(ri2pc_pkg::TWO_PI_Q13);
         end
         a4_in[l] = 16'(rr - 17'(ri2pc_pkg::PI_Q13));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff <= {tag_ff[NST-2:0], in_tag};
         u1_ff  <= u1_in;
         k2_ff  <= k2_in;
         u2_ff  <= u1_ff;
         p3_ff  <= p3_in;
         u3_ff  <= u2_ff;
         a4_ff  <= a4_in;
      end
   end

   assign out_vld = vld_ff[NST-1];
   assign out_tag = tag_ff[NST-1];
   assign out_ang = a4_ff;

endmodule

// ===== src/ri2pc_cordic.sv =====
// Pipelined rotation CORDIC: quadrant fold, one stage per step, sign fix-up stage.
module ri2pc_cordic #(
   parameter int TW    = 32,
   parameter int LANES = 2
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      en,
   input  logic                                      in_vld,
   input  logic [LANES-1:0][15:0]                    in_ang,
   input  logic [TW-1:0]                             in_tag,
   output logic                                      out_vld,
   output logic [LANES-1:0][ri2pc_pkg::CORD_W-1:0]   out_cos,
   output logic [LANES-1:0][ri2pc_pkg::CORD_W-1:0]   out_sin,
   output logic [TW-1:0]                             out_tag
);

   localparam int ITER = ri2pc_pkg::CORDIC_STEPS;
   localparam int CW   = ri2pc_pkg::CORD_W;
   localparam int ZW   = ri2pc_pkg::Z_W;

   logic [ITER+1:0]                       vld_ff;
   logic [ITER+1:0][TW-1:0]               tag_ff;
   logic [ITER:0][LANES-1:0][CW-1:0]      x_ff, y_ff;
   logic [ITER:0][LANES-1:0][ZW-1:0]      z_ff;
   logic [ITER:0][LANES-1:0]              neg_ff;
   logic [LANES-1:0][CW-1:0]              x0_in, y0_in, cos_ff, cos_in, sin_ff, sin_in;
   logic [LANES-1:0][ZW-1:0]              z0_in;
   logic [LANES-1:0]                      neg0_in;

   always_comb begin
      logic signed [15:0] a;
      for (int l = 0; l < LANES; l++) begin
         a = $signed(in_ang[l]);
         neg0_in[l] = 1'b0;
         if (a >= 16'(ri2pc_pkg::HALF_PI_Q13)) begin
            a = a - 16'(ri2pc_pkg::PI_Q13);
            neg0_in[l] = 1'b1;
         end else if (a < -16'(ri2pc_pkg::HALF_PI_Q13)) begin
            a = a + 16'(ri2pc_pkg::PI_Q13);
            neg0_in[l] = 1'b1;
         end
         z0_in[l] = ZW'(ZW'(a) <<< 3);
         x0_in[l] = CW'(ri2pc_pkg::CORDIC_GAIN);
         y0_in[l] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[ITER:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff    <= {tag_ff[ITER:0], in_tag};
         x_ff[0]   <= x0_in;
         y_ff[0]   <= y0_in;
         z_ff[0]   <= z0_in;
         neg_ff[0] <= neg0_in;
      end
   end

   for (genvar i = 0; i < ITER; i++) begin : g_iter
      logic [LANES-1:0][CW-1:0] x_in, y_in;
      logic [LANES-1:0][ZW-1:0] z_in;

      always_comb begin
         logic signed [CW-1:0] xs, ys, dx, dy;
         logic signed [ZW-1:0] zs;
         for (int l = 0; l < LANES; l++) begin
            xs = $signed(x_ff[i][l]);
            ys = $signed(y_ff[i][l]);
            zs = $signed(z_ff[i][l]);
            dx = ys >>> i;
            dy = xs >>> i;
            if (zs >= 0) begin
               x_in[l] = xs - dx;
               y_in[l] = ys + dy;
               z_in[l] = zs - ZW'(ri2pc_pkg::ATAN_Q16[i]);
            end else begin
               x_in[l] = xs + dx;
               y_in[l] = ys - dy;
               z_in[l] = zs + ZW'(ri2pc_pkg::ATAN_Q16[i]);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i+1]   <= x_in;
            y_ff[i+1]   <= y_in;
            z_ff[i+1]   <= z_in;
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         cos_in[l] = neg_ff[ITER][l] ? CW'(-$signed(x_ff[ITER][l])) : x_ff[ITER][l];
         sin_in[l] = neg_ff[ITER][l] ? CW'(-$signed(y_ff[ITER][l])) : y_ff[ITER][l];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign out_vld = vld_ff[ITER+1];
   assign out_tag = tag_ff[ITER+1];
   assign out_cos = cos_ff;
   assign out_sin = sin_ff;

endmodule

// ===== src/ri2pc_checker.sv =====
// Port-level checks for the range image to point cloud unit, bound to the top level.
module ri2pc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed or dropped while stalled");

   a_stall_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("req accepted while pipeline stalled");

   a_free_req: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req blocked with empty output");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind range_image_to_point_cloud_unit ri2pc_checker u_ri2pc_checker (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

// ===== test/range_image_to_point_cloud_unit_test.sv =====
// Testbench for the range image to point cloud unit: directed and random words against a point predictor.
module range_image_to_point_cloud_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [21:0] x;
      logic [21:0] y;
      logic [21:0] z;
   } point_type;

   class point_scoreboard;
      point_type    points_due[$];
      int           errors;
      longint       columns, rows, az_start, az_end, el_start, el_end, scale, linear;
      longint       el_table[128];
      longint       atan_tab[16];

      function new();
         atan_tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                      256, 128, 64, 32, 16, 8, 4, 2};
         columns = 1024; rows = 32; az_start = -25736; az_end = 25736;
         el_start = 2877; el_end = -3093; scale = 66970; linear = 0;
         for (int i = 0; i < 128; i++) begin
            if (i < 32) el_table[i] = longint'(ri2pc_pkg::DEF_ANGLES[i]);
            else el_table[i] = 0;
         end
      endfunction

      function void set_reg(ri2pc_pkg::csr_index_type idx, logic [23:0] v);
         case (idx)
            ri2pc_pkg::CSR_COLUMNS:     columns = v[12:0];
            ri2pc_pkg::CSR_ROWS:        rows = v[7:0];
            ri2pc_pkg::CSR_AZ_START:    az_start = longint'($signed(v[15:0]));
            ri2pc_pkg::CSR_AZ_END:      az_end = longint'($signed(v[15:0]));
            ri2pc_pkg::CSR_EL_START:    el_start = longint'($signed(v[15:0]));
            ri2pc_pkg::CSR_EL_END:      el_end = longint'($signed(v[15:0]));
            ri2pc_pkg::CSR_RANGE_SCALE: scale = v;
            ri2pc_pkg::CSR_EL_LINEAR:   linear = v[0];
         endcase
      endfunction

      function longint div_near(longint n, longint d);
         if (n >= 0) return (n + d / 2) / d;
         return -((-n + d / 2) / d);
      endfunction

      function longint wrap(longint a);
         longint t;
         t = (a + ri2pc_pkg::PI_Q13) % ri2pc_pkg::TWO_PI_Q13;
         if (t < 0) t += ri2pc_pkg::TWO_PI_Q13;
         return t - ri2pc_pkg::PI_Q13;
      endfunction

      function void rotate(longint ang, output longint c, output longint s);
         longint x, y, z, dx, dy;
         bit neg;
         neg = 0; x = ri2pc_pkg::CORDIC_GAIN; y = 0;
         if (ang >= ri2pc_pkg::HALF_PI_Q13) begin
            ang -= ri2pc_pkg::PI_Q13; neg = 1;
         end else if (ang < -ri2pc_pkg::HALF_PI_Q13) begin
            ang += ri2pc_pkg::PI_Q13; neg = 1;
         end
         z = ang * 8;
         for (int i = 0; i < 16; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_tab[i];
            end else begin
               x += dx; y -= dy; z += atan_tab[i];
            end
         end
         c = neg ? -x : x;
         s = neg ? -y : y;
      endfunction

      function logic [21:0] clip(longint v);
         if (v > ri2pc_pkg::OUT_MAX) v = ri2pc_pkg::OUT_MAX;
         if (v < ri2pc_pkg::OUT_MIN) v = ri2pc_pkg::OUT_MIN;
         return v[21:0];
      endfunction

      function void note_word(bit func, logic [6:0] row, logic [12:0] col,
                              logic [15:0] pix, logic [15:0] angle);
         longint r16, az, el, ca, sa, ce, se, h, d;
         point_type p;
         if (func) begin
            el_table[row] = longint'($signed(angle));
            return;
         end
         if (longint'(pix) * scale == 0) return;
         r16 = (longint'(pix) * scale + 128) >>> 8;
         d = (columns != 0) ? columns : 1;
         az = wrap(-div_near((az_end - az_start) * longint'(col), d) - az_start
                   - ri2pc_pkg::PI_Q13);
         if (linear != 0) begin
            if (rows <= 1) el = el_start;
            else el = div_near((el_end - el_start) * longint'(row), rows - 1) + el_start;
         end else begin
            el = el_table[row];
         end
         el = wrap(el);
         rotate(az, ca, sa);
         rotate(el, ce, se);
         h = (r16 * ce + (64'sd1 <<< 29)) >>> 30;
         p.x = clip((h * ca + (64'sd1 <<< 35)) >>> 36);
         p.y = clip((h * sa + (64'sd1 <<< 35)) >>> 36);
         p.z = clip((r16 * se + (64'sd1 <<< 35)) >>> 36);
         points_due = {points_due, p};
      endfunction

      task report(string what, logic [21:0] got, logic [21:0] want);
         errors++;
         $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
      endtask

      task check_word(logic [71:0] w);
         point_type p;
         if (points_due.size() == 0) begin
            report("unexpected word", w[21:0], 22'd0);
            return;
         end
         p = points_due.pop_front();
         if (w[21:0] !== p.x) report("x", w[21:0], p.x);
         if (w[43:22] !== p.y) report("y", w[43:22], p.y);
         if (w[65:44] !== p.z) report("z", w[65:44], p.z);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        csr_wen = 0;
   logic [2:0]  csr_addr = '0;
   logic [23:0] csr_wdata = '0;

   point_scoreboard sb = new();
   bit  calm = 0;
   int  hold_off = 0;
   int  rsp_burst = 0;
   longint cycles = 0;

   range_image_to_point_cloud_unit u_dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > 500000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
      if (hold_off > 0) begin
         hold_off--;
         rsp_tready <= 0;
      end else if (rsp_burst > 0) begin
         rsp_burst--;
         rsp_tready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_burst = $urandom_range(1, 12) - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= !reset;
      end
   end

   task automatic send_word(bit func, logic [6:0] row, logic [12:0] col,
                            logic [15:0] pix, logic [15:0] angle);
      int gap;
      gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= func;
      req_tdata  <= {4'b0, angle, pix, col, row};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sb.note_word(func, row, col, pix, angle);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      do @(posedge clock); while (sb.points_due.size() != 0);
      repeat (70) @(posedge clock);
   endtask

   task automatic write_reg(ri2pc_pkg::csr_index_type idx, logic [23:0] v);
      csr_wen   <= 1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
   endtask

   task automatic setup(int cols, int rws, int azs, int aze, int els, int ele,
                        int scl, bit lin);
      write_reg(ri2pc_pkg::CSR_COLUMNS, 24'(cols));
      write_reg(ri2pc_pkg::CSR_ROWS, 24'(rws));
      write_reg(ri2pc_pkg::CSR_AZ_START, 24'(azs));
      write_reg(ri2pc_pkg::CSR_AZ_END, 24'(aze));
      write_reg(ri2pc_pkg::CSR_EL_START, 24'(els));
      write_reg(ri2pc_pkg::CSR_EL_END, 24'(ele));
      write_reg(ri2pc_pkg::CSR_RANGE_SCALE, 24'(scl));
      write_reg(ri2pc_pkg::CSR_EL_LINEAR, 24'(lin));
      csr_wen <= 0;
      @(posedge clock);
   endtask

   function automatic int pick_angle();
      case ($urandom_range(0, 3))
         0: return -25736;
         1: return 25736;
         default: return $urandom_range(0, 51472) - 25736;
      endcase
   endfunction

   function automatic bit ph_lin();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic random_words(int n);
      logic [15:0] pix;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 15))
            0: pix = 16'd0;
            1, 2: pix = 16'hFFFF;
            3, 4, 5: pix = 16'($urandom_range(1, 255));
            default: pix = 16'($urandom);
         endcase
         send_word($urandom_range(0, 9) == 0, 7'($urandom), 13'($urandom), pix,
                   16'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // defaults, table mode
      send_word(0, 0, 0, 16'hFFFF, 0);
      send_word(0, 127, 8191, 16'hFFFF, 0);
      send_word(0, 31, 512, 1000, 0);
      send_word(0, 5, 100, 0, 0);
      send_word(1, 0, 0, 0, 16'h8000);
      send_word(1, 127, 0, 0, 16'h7FFF);
      send_word(1, 64, 0, 0, 16'h3244);
      send_word(0, 0, 8191, 16'h8000, 0);
      send_word(0, 127, 0, 16'h8000, 0);
      send_word(0, 64, 4096, 40000, 0);
      send_word(0, 40, 1, 1, 0);
      drain();

      setup(1, 1, -25736, 25736, -25736, 25736, 16777215, 1);
      send_word(0, 0, 0, 16'hFFFF, 0);
      send_word(0, 127, 8191, 16'hFFFF, 0);
      send_word(0, 1, 1, 1, 0);
      send_word(0, 77, 4000, 12345, 0);
      drain();

      setup(0, 0, 25736, -25736, 25736, -25736, 0, 1);
      send_word(0, 3, 3, 16'hFFFF, 0);
      drain();
      setup(0, 0, 25736, -25736, 25736, -25736, 1, 1);
      send_word(0, 3, 3, 16'hFFFF, 0);
      send_word(0, 127, 8191, 1, 0);
      send_word(0, 9, 8191, 300, 0);
      drain();
      setup(8191, 2, 0, 0, 0, 0, 66970, 1);
      send_word(0, 0, 0, 500, 0);
      send_word(0, 1, 8191, 500, 0);
      send_word(0, 127, 8191, 500, 0);
      drain();

      random_words(130);
      hold_off = 300;
      random_words(150);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         setup($urandom_range(0, 8191), $urandom_range(0, 255), pick_angle(), pick_angle(),
               pick_angle(), pick_angle(),
               (ph == 1) ? $urandom : $urandom_range(1, 200000), $urandom_range(0, 1));
         random_words(60);
         drain();
         random_words(50);
         drain();
      end

      calm = 1;
      setup(2048, 128, -25736, 25736, 3000, -3000, 66970, ph_lin());
      random_words(30);
      drain();

      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
